[design/shell_line_tokenizer_unit_defines.svh]
// assertion macros for the shell line tokenizer
`ifndef SHELL_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/slt_pkg.sv]
`default_nettype none

package slt_pkg;

    // quote stack
    localparam int STACK_DEPTH = 16;
    localparam int SD_IW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SD_DW       = $clog2(STACK_DEPTH + 1);

    // results one input can cause
    localparam int MAX_RES = 4;

    // fixed characters
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // register reset values
    localparam logic [31:0] RST_DELIM_CHARS = 32'd2336;
    localparam logic [2:0]  RST_DELIM_COUNT = 3'd2;
    localparam logic [7:0]  RST_ESCAPE      = 8'd92;
    localparam logic [7:0]  RST_COMMAND     = 8'd59;
    localparam logic [7:0]  RST_OR          = 8'd124;
    localparam logic [7:0]  RST_AND         = 8'd38;
    localparam logic [7:0]  RST_COMMENT     = 8'd35;
    localparam logic [2:0]  MAX_DELIMS      = 3'd4;

    typedef enum logic [2:0] {
        REG_DELIM_CHARS = 3'd0,
        REG_DELIM_COUNT = 3'd1,
        REG_ESCAPE      = 3'd2,
        REG_COMMAND     = 3'd3,
        REG_OR          = 3'd4,
        REG_AND         = 3'd5,
        REG_COMMENT     = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        Q_SINGLE  = 2'd1,
        Q_DOUBLE  = 2'd2,
        Q_ESCAPED = 2'd3
    } t_quote;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_OR   = 2'd1,
        PEND_AND  = 2'd2
    } t_pend;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
        logic       ovf;
    } t_result;

    function automatic t_result f_res(t_kind kind, logic [7:0] c, logic ovf);
        t_result r;
        r.kind = kind;
        r.chr  = (kind == KIND_CHAR) ? c : 8'd0;
        r.ovf  = ovf;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/shell_line_tokenizer_unit.sv]
`default_nettype none
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// in        | in        | i_in_valid / o_in_stall    | i_char_in, i_end_of_line
// out       | out       | o_out_valid / i_out_stall  | o_kind, o_char_out,
//           |           |                            | o_nesting_overflow, o_last
// cfg       | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one input byte per cycle enters the input register while o_in_stall is low; its
// results (zero to four) are built from it and loaded into the result list once the list is free
// the result list drains one result per cycle while i_out_stall is low; a byte's results
// leave in order with o_last on the final one; unstalled bytes causing one result flow at one per cycle
// reset is synchronous, active low, and skips the quote stack; cfg writes are always accepted and registered
// an output stall backs up into the input register, then into o_in_stall
`include "shell_line_tokenizer_unit_defines.svh"

module shell_line_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_end_of_line,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic             o_nesting_overflow,
    output logic             o_last,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0] r_delim_chars;
    logic [2:0]  r_delim_count;
    logic [7:0]  r_escape;
    logic [7:0]  r_command;
    logic [7:0]  r_or;
    logic [7:0]  r_and;
    logic [7:0]  r_comment;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_char;
    logic        r_in_eol;

    // tokenizer state
    slt_pkg::t_quote               r_stack [slt_pkg::STACK_DEPTH];
    logic [slt_pkg::SD_DW-1:0]     r_depth;
    logic                          r_tok;
    slt_pkg::t_pend                r_pend;
    logic                          r_comm;
    logic                          r_ovf;

    // result list
    slt_pkg::t_result              r_res [slt_pkg::MAX_RES];
    logic [2:0]                    r_cnt;
    logic [1:0]                    r_idx;

    // next values
    slt_pkg::t_result              n_res [slt_pkg::MAX_RES];
    logic [2:0]                    n_cnt;
    logic [slt_pkg::SD_DW-1:0]     n_depth;
    logic                          n_tok;
    slt_pkg::t_pend                n_pend;
    logic                          n_comm;
    logic                          n_ovf;
    logic                          n_push;
    slt_pkg::t_quote               n_push_q;

    // handshake
    logic in_acc;
    logic out_take;
    logic out_last;
    logic list_free;
    logic load;

    assign o_cfg_ready = 1'b1;

    assign o_out_valid = (r_cnt != 3'd0);
    assign out_last    = (3'({1'b0, r_idx}) == (r_cnt - 3'd1));
    assign out_take    = o_out_valid && !i_out_stall;
    // list can take a new batch when empty or when its final result leaves now
    assign list_free   = !o_out_valid || (out_take && out_last);
    assign load        = r_in_vld && list_free;
    assign o_in_stall  = r_in_vld && !load;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign o_kind             = r_res[r_idx].kind;
    assign o_char_out         = r_res[r_idx].chr;
    assign o_nesting_overflow = r_res[r_idx].ovf;
    assign o_last             = out_last;

    // per-byte tokenizer step
    logic                      is_delim;
    logic [2:0]                delim_n;
    logic                      joins;
    logic                      skip;
    logic                      tokch;
    logic                      push_req;
    slt_pkg::t_quote           push_q;
    logic                      pop;
    slt_pkg::t_quote           top;
    logic [7:0]                c;

    always_comb begin
        c       = r_in_char;
        delim_n = (r_delim_count > slt_pkg::MAX_DELIMS) ? slt_pkg::MAX_DELIMS : r_delim_count;
        is_delim = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < delim_n) && (r_delim_chars[8*i +: 8] == c)) begin
                is_delim = 1'b1;
            end
        end
        // top of stack, only meaningful when depth is nonzero
        top = r_stack[slt_pkg::SD_IW'(r_depth - slt_pkg::SD_DW'(1))];
    end

    always_comb begin
        for (int i = 0; i < slt_pkg::MAX_RES; i++) begin
            n_res[i] = '0;
        end
        n_cnt    = 3'd0;
        n_depth  = r_depth;
        n_tok    = r_tok;
        n_pend   = r_pend;
        n_comm   = r_comm;
        n_ovf    = r_ovf;
        n_push   = 1'b0;
        n_push_q = slt_pkg::Q_SINGLE;
        joins    = 1'b0;
        skip     = 1'b0;
        tokch    = 1'b0;
        push_req = 1'b0;
        push_q   = slt_pkg::Q_SINGLE;
        pop      = 1'b0;

        if (!r_comm) begin
            // a pending operator first tries to join with this byte
            if (r_pend != slt_pkg::PEND_NONE) begin
                joins  = (c == r_and) || ((r_pend == slt_pkg::PEND_OR) && (c == r_or));
                n_pend = slt_pkg::PEND_NONE;
                if (joins) begin
                    n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_CHAR, c, n_ovf);
                    n_cnt = n_cnt + 3'd1;
                    n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                    n_cnt = n_cnt + 3'd1;
                    n_tok = 1'b0;
                    skip  = 1'b1;
                end else if (n_tok) begin
                    n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                    n_cnt = n_cnt + 3'd1;
                    n_tok = 1'b0;
                end
            end

            if (!skip) begin
                if (r_depth == '0) begin
                    // outside quotes
                    if (is_delim) begin
                        if (n_tok) begin
                            n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                            n_cnt = n_cnt + 3'd1;
                            n_tok = 1'b0;
                        end
                    end else if (c == slt_pkg::CH_SQUOTE) begin
                        push_req = 1'b1;
                        push_q   = slt_pkg::Q_SINGLE;
                        tokch    = 1'b1;
                    end else if (c == slt_pkg::CH_DQUOTE) begin
                        push_req = 1'b1;
                        push_q   = slt_pkg::Q_DOUBLE;
                        tokch    = 1'b1;
                    end else if (c == r_escape) begin
                        push_req = 1'b1;
                        push_q   = slt_pkg::Q_ESCAPED;
                        tokch    = 1'b1;
                    end else if ((c == slt_pkg::CH_NL) || (c == r_command)) begin
                        // separator is a token of its own
                        if (n_tok) begin
                            n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                            n_cnt = n_cnt + 3'd1;
                            n_tok = 1'b0;
                        end
                        n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_CHAR, c, n_ovf);
                        n_cnt = n_cnt + 3'd1;
                        n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                        n_cnt = n_cnt + 3'd1;
                    end else if ((c == r_or) || (c == r_and)) begin
                        if (n_tok) begin
                            n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                            n_cnt = n_cnt + 3'd1;
                            n_tok = 1'b0;
                        end
                        tokch  = 1'b1;
                        n_pend = (c == r_or) ? slt_pkg::PEND_OR : slt_pkg::PEND_AND;
                    end else if (c == r_comment) begin
                        if (n_tok) begin
                            n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                            n_cnt = n_cnt + 3'd1;
                            n_tok = 1'b0;
                        end
                        n_comm = 1'b1;
                    end else begin
                        tokch = 1'b1;
                    end
                end else begin
                    // inside quotes: everything is a token character
                    tokch = 1'b1;
                    if (top == slt_pkg::Q_ESCAPED) begin
                        pop = 1'b1;
                    end else if (c == slt_pkg::CH_SQUOTE) begin
                        if (top == slt_pkg::Q_SINGLE) begin
                            pop = 1'b1;
                        end else begin
                            push_req = 1'b1;
                            push_q   = slt_pkg::Q_SINGLE;
                        end
                    end else if (c == slt_pkg::CH_DQUOTE) begin
                        if (top == slt_pkg::Q_DOUBLE) begin
                            pop = 1'b1;
                        end else begin
                            push_req = 1'b1;
                            push_q   = slt_pkg::Q_DOUBLE;
                        end
                    end else if (c == r_escape) begin
                        push_req = 1'b1;
                        push_q   = slt_pkg::Q_ESCAPED;
                    end
                end

                // stack full: push is dropped and the sticky flag set
                if (push_req) begin
                    if (r_depth >= slt_pkg::SD_DW'(slt_pkg::STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_push   = 1'b1;
                        n_push_q = push_q;
                        n_depth  = r_depth + slt_pkg::SD_DW'(1);
                    end
                end
                if (pop) begin
                    n_depth = r_depth - slt_pkg::SD_DW'(1);
                end
                if (tokch) begin
                    n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_CHAR, c, n_ovf);
                    n_cnt = n_cnt + 3'd1;
                    n_tok = 1'b1;
                end
            end
        end

        // end of line closes the token, reports, and clears state
        if (r_in_eol) begin
            if (n_tok) begin
                n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_END, 8'd0, n_ovf);
                n_cnt = n_cnt + 3'd1;
            end
            n_res[n_cnt[1:0]] = slt_pkg::f_res(slt_pkg::KIND_LINE, 8'd0, n_ovf);
            n_cnt   = n_cnt + 3'd1;
            n_depth = '0;
            n_tok   = 1'b0;
            n_pend  = slt_pkg::PEND_NONE;
            n_comm  = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_chars <= slt_pkg::RST_DELIM_CHARS;
            r_delim_count <= slt_pkg::RST_DELIM_COUNT;
            r_escape      <= slt_pkg::RST_ESCAPE;
            r_command     <= slt_pkg::RST_COMMAND;
            r_or          <= slt_pkg::RST_OR;
            r_and         <= slt_pkg::RST_AND;
            r_comment     <= slt_pkg::RST_COMMENT;
            r_in_vld      <= 1'b0;
            r_depth       <= '0;
            r_tok         <= 1'b0;
            r_pend        <= slt_pkg::PEND_NONE;
            r_comm        <= 1'b0;
            r_ovf         <= 1'b0;
            r_cnt         <= 3'd0;
            r_idx         <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (slt_pkg::t_cfg_reg'(i_cfg_index))
                    slt_pkg::REG_DELIM_CHARS: r_delim_chars <= i_cfg_data;
                    slt_pkg::REG_DELIM_COUNT: r_delim_count <= i_cfg_data[2:0];
                    slt_pkg::REG_ESCAPE:      r_escape      <= i_cfg_data[7:0];
                    slt_pkg::REG_COMMAND:     r_command     <= i_cfg_data[7:0];
                    slt_pkg::REG_OR:          r_or          <= i_cfg_data[7:0];
                    slt_pkg::REG_AND:         r_and         <= i_cfg_data[7:0];
                    slt_pkg::REG_COMMENT:     r_comment     <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            r_in_vld <= in_acc || (r_in_vld && !load);

            if (load) begin
                r_depth <= n_depth;
                r_tok   <= n_tok;
                r_pend  <= n_pend;
                r_comm  <= n_comm;
                r_ovf   <= n_ovf;
                r_cnt   <= n_cnt;
                r_idx   <= 2'd0;
            end else if (out_take) begin
                if (out_last) begin
                    r_cnt <= 3'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_char_in;
            r_in_eol  <= i_end_of_line;
        end
        if (load) begin
            r_res <= n_res;
        end
    end

    // quote stack, contents undefined until pushed
    always_ff @(posedge i_clk) begin
        if (load && n_push) begin
            r_stack[slt_pkg::SD_IW'(r_depth)] <= n_push_q;
        end
    end

    `SLT_ASSERT_NOW(a_depth_bound, 1'b1,
        r_depth <= slt_pkg::SD_DW'(slt_pkg::STACK_DEPTH), "quote stack depth out of range")

    `SLT_ASSERT_NOW(a_idx_in_list, o_out_valid,
        (3'({1'b0, r_idx}) < r_cnt) && (r_cnt <= 3'(slt_pkg::MAX_RES)), "result index past list")

    `SLT_ASSERT_NOW(a_line_is_last, o_out_valid && (o_kind == slt_pkg::KIND_LINE),
        o_last, "line finished result is not the final one")

    `SLT_ASSERT_NEXT(a_eol_clears, load && r_in_eol,
        (r_depth == '0) && !r_tok && !r_comm && !r_ovf && (r_pend == slt_pkg::PEND_NONE),
        "state not cleared after end of line")

    `SLT_ASSERT_NOW(a_stall_hold, r_in_vld && o_out_valid && i_out_stall,
        o_in_stall, "input taken while results are blocked")

endmodule

`default_nettype wire
